/* hw/rtl/pls_pkg.sv */
// Shared constants and fixed-point helpers for the PLS predictor.
`default_nettype none
package pls_pkg;
  localparam int MaxFeatures  = 16;
  localparam int MaxLatent    = 8;
  localparam int MaxResponses = 4;
  localparam int FracBits     = 16;

  localparam int FeatW = $clog2(MaxFeatures);
  localparam int LatW  = $clog2(MaxLatent);
  localparam int RespW = (MaxResponses > 1) ? $clog2(MaxResponses) : 1;

  localparam logic [2:0] TblWeight = 3'd0;
  localparam logic [2:0] TblXload  = 3'd1;
  localparam logic [2:0] TblYload  = 3'd2;
  localparam logic [2:0] TblCoef   = 3'd3;
  localparam logic [2:0] TblXavg   = 3'd4;
  localparam logic [2:0] TblXrecip = 3'd5;
  localparam logic [2:0] TblYscale = 3'd6;
  localparam logic [2:0] TblYavg   = 3'd7;

  localparam logic [2:0] RegFeatures  = 3'd0;
  localparam logic [2:0] RegLatent    = 3'd1;
  localparam logic [2:0] RegResponses = 3'd2;
  localparam logic [2:0] RegCenter    = 3'd3;
  localparam logic [2:0] RegScale     = 3'd4;
  localparam logic [2:0] RegUnscale   = 3'd5;
  localparam logic [2:0] RegOffset    = 3'd6;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [63:0] round_prod(input logic signed [63:0] p);
    round_prod = (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/pls_score_and_response_predict_unit.sv */
// Top level of the PLS predictor: table memories, row buffer and a sequenced MAC.
//
// channel   dir  ports                                          beat
// command   in   start_i, busy_o, op_i..sample_last_i            start_i & !busy_o
// result    out  result_valid_o, predicted_o..run_last_o         result_valid_o, 1 cycle
// config    in   psel_i..pwdata_i, prdata_o, pready_o            psel&penable&pwrite
//
// A table load or a plain feature does not raise busy_o. A feature marked last holds busy_o
// through preprocessing of every feature plus, per latent variable, the score dot product,
// deflation and response updates on the single multiplier with registered table reads.
// The last result beat arrives as busy_o falls; results cannot be stalled.
// Reset is asynchronous, clears control state and result_valid_o and loads the config
// registers with their defaults; table contents are undefined until written.
`default_nettype none
module pls_score_and_response_predict_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        op_i,
  input  wire logic [2:0]  table_sel_i,
  input  wire logic [3:0]  row_index_i,
  input  wire logic [2:0]  lv_index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic        sample_last_i,
  output logic             result_valid_o,
  output logic signed [31:0] predicted_o,
  output logic [3:0]       lv_count_o,
  output logic [1:0]       response_index_o,
  output logic signed [31:0] score_o,
  output logic             run_last_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);
  import pls_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SPreRd = 4'd1;
  localparam logic [3:0] SPreMl = 4'd2;
  localparam logic [3:0] SPreWr = 4'd3;
  localparam logic [3:0] SDotRd = 4'd4;
  localparam logic [3:0] SDotAc = 4'd5;
  localparam logic [3:0] SDefRd = 4'd6;
  localparam logic [3:0] SDefMl = 4'd7;
  localparam logic [3:0] SDefWr = 4'd8;
  localparam logic [3:0] SBtRd  = 4'd9;
  localparam logic [3:0] SBtMl  = 4'd10;
  localparam logic [3:0] SYRd   = 4'd11;
  localparam logic [3:0] SYMl   = 4'd12;
  localparam logic [3:0] SYSc   = 4'd13;
  localparam logic [3:0] SYOut  = 4'd14;

  logic [4:0] features_q;
  logic [3:0] latent_q;
  logic [2:0] responses_q;
  logic center_q, scale_q, unscale_q, offset_q;

  logic signed [31:0] weight_mem [MaxFeatures*MaxLatent];
  logic signed [31:0] xload_mem  [MaxFeatures*MaxLatent];
  logic signed [31:0] yload_mem  [MaxResponses*MaxLatent];
  logic signed [31:0] coef_mem   [MaxLatent];
  logic signed [31:0] xavg_mem   [MaxFeatures];
  logic signed [31:0] xrecip_mem [MaxFeatures];
  logic signed [31:0] yscale_mem [MaxResponses];
  logic signed [31:0] yavg_mem   [MaxResponses];
  logic signed [31:0] row_mem    [MaxFeatures];
  logic signed [31:0] x_mem      [MaxFeatures];
  logic signed [31:0] acc_mem    [MaxResponses];

  logic [3:0] state_q, state_d;
  logic [FeatW-1:0] j_q, j_d;
  logic [LatW-1:0] lv_q, lv_d;
  logic [RespW-1:0] r_q, r_d;
  logic signed [63:0] dot_q, dot_d;
  logic signed [31:0] t_q, t_d, bt_q, bt_d, v_q, v_d;
  logic signed [63:0] prod_q, prod_d;

  logic signed [31:0] rd_a_q, rd_b_q, rd_c_q, rd_d_q;

  logic [FeatW:0] nf;
  logic [LatW:0] nl;
  logic [RespW:0] nr;
  logic cmd_beat, cfg_wr, j_end, lv_end, r_end;

  assign pready_o = 1'b1;
  assign busy_o   = (state_q != SIdle);
  assign cmd_beat = start_i && !busy_o;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    if (features_q == 5'd0) begin
      nf = (FeatW+1)'(1);
    end else if (features_q > 5'(MaxFeatures)) begin
      nf = (FeatW+1)'(MaxFeatures);
    end else begin
      nf = (FeatW+1)'(features_q);
    end
    if (latent_q == 4'd0) begin
      nl = (LatW+1)'(1);
    end else if (latent_q > 4'(MaxLatent)) begin
      nl = (LatW+1)'(MaxLatent);
    end else begin
      nl = (LatW+1)'(latent_q);
    end
    if (responses_q == 3'd0) begin
      nr = (RespW+1)'(1);
    end else if (responses_q > 3'(MaxResponses)) begin
      nr = (RespW+1)'(MaxResponses);
    end else begin
      nr = (RespW+1)'(responses_q);
    end
  end

  assign j_end  = ((FeatW+1)'(j_q) + 1'b1) == nf;
  assign lv_end = ((LatW+1)'(lv_q) + 1'b1) == nl;
  assign r_end  = ((RespW+1)'(r_q) + 1'b1) == nr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      features_q  <= 5'd16;
      latent_q    <= 4'd8;
      responses_q <= 3'd1;
      center_q    <= 1'b1;
      scale_q     <= 1'b0;
      unscale_q   <= 1'b0;
      offset_q    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr_i[4:2])
        RegFeatures:  features_q  <= pwdata_i[4:0];
        RegLatent:    latent_q    <= pwdata_i[3:0];
        RegResponses: responses_q <= pwdata_i[2:0];
        RegCenter:    center_q    <= pwdata_i[0];
        RegScale:     scale_q     <= pwdata_i[0];
        RegUnscale:   unscale_q   <= pwdata_i[0];
        RegOffset:    offset_q    <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[4:2])
      RegFeatures:  prdata_o = {27'd0, features_q};
      RegLatent:    prdata_o = {28'd0, latent_q};
      RegResponses: prdata_o = {29'd0, responses_q};
      RegCenter:    prdata_o = {31'd0, center_q};
      RegScale:     prdata_o = {31'd0, scale_q};
      RegUnscale:   prdata_o = {31'd0, unscale_q};
      RegOffset:    prdata_o = {31'd0, offset_q};
      default:      prdata_o = 32'd0;
    endcase
  end

  // table loads and feature row writes
  logic fok, rok;
  logic [FeatW+LatW-1:0] fidx;
  logic [RespW+LatW-1:0] ridx;
  assign fok  = ({1'b0, row_index_i} < 5'(MaxFeatures)) && ({1'b0, lv_index_i} < 4'(MaxLatent));
  assign rok  = {1'b0, row_index_i} < 5'(MaxResponses);
  assign fidx = {row_index_i[FeatW-1:0], lv_index_i[LatW-1:0]};
  assign ridx = {row_index_i[RespW-1:0], lv_index_i[LatW-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_beat && !op_i) begin
      unique case (table_sel_i)
        TblWeight: if (fok) weight_mem[fidx] <= value_i;
        TblXload:  if (fok) xload_mem[fidx] <= value_i;
        TblYload:  if (rok && ({1'b0, lv_index_i} < 4'(MaxLatent))) yload_mem[ridx] <= value_i;
        TblCoef: begin
          if ({1'b0, lv_index_i} < 4'(MaxLatent)) coef_mem[lv_index_i[LatW-1:0]] <= value_i;
        end
        TblXavg: begin
          if ({1'b0, row_index_i} < 5'(MaxFeatures)) begin
            xavg_mem[row_index_i[FeatW-1:0]] <= value_i;
          end
        end
        TblXrecip: begin
          if ({1'b0, row_index_i} < 5'(MaxFeatures)) begin
            xrecip_mem[row_index_i[FeatW-1:0]] <= value_i;
          end
        end
        TblYscale: if (rok) yscale_mem[row_index_i[RespW-1:0]] <= value_i;
        TblYavg:   if (rok) yavg_mem[row_index_i[RespW-1:0]] <= value_i;
        default: ;
      endcase
    end
    if (cmd_beat && op_i && ({1'b0, row_index_i} < 5'(MaxFeatures))) begin
      row_mem[row_index_i[FeatW-1:0]] <= value_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rd_a_q <= row_mem[j_q];
    rd_b_q <= xavg_mem[j_q];
    rd_c_q <= xrecip_mem[j_q];
    rd_d_q <= x_mem[j_q];
  end

  logic signed [31:0] w_rd_q, p_rd_q, q_rd_q, b_rd_q, ys_rd_q, ya_rd_q, acc_rd_q;
  always_ff @(posedge clk_i) begin
    w_rd_q   <= weight_mem[{j_q, lv_q}];
    p_rd_q   <= xload_mem[{j_d, lv_q}];
    q_rd_q   <= yload_mem[{r_d, lv_q}];
    b_rd_q   <= coef_mem[lv_q];
    ys_rd_q  <= yscale_mem[r_q];
    ya_rd_q  <= yavg_mem[r_q];
    acc_rd_q <= acc_mem[r_q];
  end

  logic x_we, acc_we;
  logic signed [31:0] x_wd, acc_wd;
  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[j_q] <= x_wd;
    if (acc_we) acc_mem[r_q] <= acc_wd;
  end

  logic signed [31:0] cen, rnd, ysum, yv;
  logic out_v_d;
  logic signed [31:0] out_y_d;

  always_comb begin
    state_d = state_q;
    j_d = j_q;
    lv_d = lv_q;
    r_d = r_q;
    dot_d = dot_q;
    t_d = t_q;
    bt_d = bt_q;
    v_d = v_q;
    prod_d = prod_q;
    x_we = 1'b0;
    x_wd = v_q;
    acc_we = 1'b0;
    acc_wd = 32'sd0;
    out_v_d = 1'b0;
    out_y_d = 32'sd0;
    cen = center_q ? sat32(64'(rd_a_q) - 64'(rd_b_q)) : rd_a_q;
    rnd = sat32(round_prod(prod_q));
    ysum = sat32(64'(acc_rd_q) + 64'(rnd));
    yv = 32'sd0;
    unique case (state_q)
      SIdle: begin
        if (cmd_beat && op_i && sample_last_i) begin
          state_d = SPreRd;
          j_d = '0;
          lv_d = '0;
        end
      end
      SPreRd: state_d = SPreMl;
      SPreMl: begin
        v_d = cen;
        prod_d = 64'(cen) * 64'(rd_c_q);
        state_d = SPreWr;
        if (scale_q && rd_c_q == 32'sd0) begin
          v_d = 32'sd0;
        end
      end
      SPreWr: begin
        x_we = 1'b1;
        x_wd = (scale_q && v_q != 32'sd0) ? rnd : v_q;
        if (scale_q && v_q == 32'sd0) x_wd = 32'sd0;
        if (j_end) begin
          j_d = '0;
          dot_d = '0;
          state_d = SDotRd;
        end else begin
          j_d = j_q + 1'b1;
          state_d = SPreRd;
        end
      end
      SDotRd: state_d = SDotAc;
      SDotAc: begin
        prod_d = 64'(rd_d_q) * 64'(w_rd_q);
        state_d = SDefRd;
      end
      SDefRd: begin
        dot_d = dot_q + round_prod(prod_q);
        if (j_end) begin
          t_d = sat32(dot_d);
          j_d = '0;
          state_d = SDefMl;
        end else begin
          j_d = j_q + 1'b1;
          state_d = SDotRd;
        end
      end
      SDefMl: begin
        prod_d = 64'(t_q) * 64'(p_rd_q);
        state_d = SDefWr;
      end
      SDefWr: begin
        x_we = 1'b1;
        x_wd = sat32(64'(rd_d_q) - 64'(rnd));
        if (j_end) begin
          r_d = '0;
          state_d = SBtRd;
        end else begin
          j_d = j_q + 1'b1;
          state_d = SDefMl;
        end
      end
      SBtRd: begin
        prod_d = 64'(b_rd_q) * 64'(t_q);
        state_d = SBtMl;
      end
      SBtMl: begin
        bt_d = rnd;
        state_d = SYRd;
      end
      SYRd: begin
        prod_d = 64'(bt_q) * 64'(q_rd_q);
        state_d = SYMl;
      end
      SYMl: begin
        yv = (lv_q == '0) ? rnd : ysum;
        acc_we = 1'b1;
        acc_wd = yv;
        v_d = yv;
        prod_d = 64'(yv) * 64'(ys_rd_q);
        state_d = SYSc;
      end
      SYSc: begin
        if (offset_q && unscale_q) v_d = rnd;
        state_d = SYOut;
      end
      SYOut: begin
        out_v_d = 1'b1;
        out_y_d = offset_q ? sat32(64'(v_q) + 64'(ya_rd_q)) : v_q;
        if (!r_end) begin
          r_d = r_q + 1'b1;
          state_d = SYRd;
        end else if (!lv_end) begin
          lv_d = lv_q + 1'b1;
          j_d = '0;
          dot_d = '0;
          state_d = SDotRd;
        end else begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      j_q <= '0;
      lv_q <= '0;
      r_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q <= j_d;
      lv_q <= lv_d;
      r_q <= r_d;
      result_valid_o <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q <= dot_d;
    t_q <= t_d;
    bt_q <= bt_d;
    v_q <= v_d;
    prod_q <= prod_d;
    if (out_v_d) begin
      predicted_o <= out_y_d;
      lv_count_o <= 4'(lv_q) + 4'd1;
      response_index_o <= 2'(r_q);
      score_o <= t_q;
      run_last_o <= r_end && lv_end;
    end
  end

  a_busy_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_beat && op_i && sample_last_i |=> busy_o) else $error("run did not start");
  a_out_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_d |-> busy_o) else $error("result outside a run");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && run_last_o |-> !busy_o) else $error("run kept going after last");
endmodule
`default_nettype wire
